// ===== rtl/core/wspa_pkg.sv =====
package wspa_pkg;

  localparam int WHEELS_DEF = 4;
  localparam int IDX_W      = 5;
  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;
  localparam int GAIN_W     = 16;
  localparam int SPEED_W    = 16;
  localparam int ERR_W      = 17;
  localparam int PE_W       = 18;
  localparam int INTEG_W    = 21;
  localparam int INC_W      = 34;
  localparam int ISUM_W     = 35;
  localparam int PDIFF_W    = 18;
  localparam int DDIFF_W    = 19;
  localparam int PPROD_W    = 35;
  localparam int DPROD_W    = 36;
  localparam int SUM_W      = 38;
  localparam int FRAC_W     = 8;

  localparam logic signed [ERR_W-1:0]   ERR_DEADBAND  = 17'sd20;
  localparam logic signed [ERR_W-1:0]   ERR_SEP_LIMIT = 17'sd8000;
  localparam logic signed [SPEED_W-1:0] WINDUP_SPEED  = 16'sd7000;
  localparam logic signed [ISUM_W-1:0]  INTEG_LIM_Q8  = 35'sd768000;
  localparam logic signed [SUM_W-1:0]   OUT_LIM_Q8    = 38'sd6400000;
  localparam logic signed [SPEED_W-1:0] DRIVE_LIM     = 16'sd25000;
  localparam logic [SUM_W-1:0]          ROUND_NEG     = 38'd255;

  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd1024;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 16'd256;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd0;

  typedef enum logic [1:0] {
    REG_PROP  = 2'd0,
    REG_INTEG = 2'd1,
    REG_DERIV = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0] prop;
    logic [GAIN_W-1:0] integ;
    logic [GAIN_W-1:0] deriv;
  } gains_t;

  typedef struct packed {
    logic signed [PE_W-1:0]    prev_err;
    logic signed [PE_W-1:0]    prev_prev_err;
    logic signed [INTEG_W-1:0] integ;
  } state_t;

endpackage

// ===== rtl/core/wspa_cfg_regs.sv =====
module wspa_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wspa_pkg::PADDR_W-1:0] paddr,
  input  logic [wspa_pkg::PDATA_W-1:0] pwdata,
  output logic [wspa_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output wspa_pkg::gains_t             gains
);
  import wspa_pkg::*;

  gains_t   gains_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign gains  = gains_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r.prop  <= PROP_GAIN_RST;
      gains_r.integ <= INTEG_GAIN_RST;
      gains_r.deriv <= DERIV_GAIN_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_PROP:  gains_r.prop  <= pwdata[GAIN_W-1:0];
        REG_INTEG: gains_r.integ <= pwdata[GAIN_W-1:0];
        REG_DERIV: gains_r.deriv <= pwdata[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PROP:  prdata = PDATA_W'(gains_r.prop);
      REG_INTEG: prdata = PDATA_W'(gains_r.integ);
      REG_DERIV: prdata = PDATA_W'(gains_r.deriv);
      default:   prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/wspa_state_mem.sv =====
module wspa_state_mem #(
  parameter  int WHEELS = wspa_pkg::WHEELS_DEF,
  localparam int AW     = (WHEELS > 1) ? $clog2(WHEELS) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output wspa_pkg::state_t rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  wspa_pkg::state_t wr_data
);
  import wspa_pkg::*;

  state_t            mem [WHEELS];
  logic [WHEELS-1:0] valid_r;
  state_t            mem_q_r;
  logic              mem_q_valid_r;
  logic [AW-1:0]     q_addr_r;
  logic              lw_valid_r;
  logic [AW-1:0]     lw_addr_r;
  state_t            lw_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
      lw_addr_r    <= wr_addr;
      lw_data_r    <= wr_data;
    end
    if (rd_en) begin
      mem_q_r  <= mem[rd_addr];
      q_addr_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r       <= '0;
      mem_q_valid_r <= 1'b0;
      lw_valid_r    <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
        lw_valid_r       <= 1'b1;
      end
      if (rd_en) begin
        mem_q_valid_r <= valid_r[rd_addr];
      end
    end
  end

  // forward the newest write of the same wheel over the stale read
  always_comb begin
    if (lw_valid_r && (lw_addr_r == q_addr_r)) begin
      rd_data = lw_data_r;
    end else if (mem_q_valid_r) begin
      rd_data = mem_q_r;
    end else begin
      rd_data = '0;
    end
  end

endmodule

// ===== rtl/core/wheel_speed_pid_antiwindup.sv =====
// Four-channel wheel speed PID controller with integral separation and one-sided
// anti-windup. Each input beat names a wheel and carries its measured and target
// speed; one output beat with the saturated drive command follows for every input
// beat, in order. The block takes one beat per clock while the output side is not
// stalled; the per-wheel state (last two errors and the Q.8 integral) sits in one
// synchronous memory that is read one stage ahead of the update and written back
// as the beat leaves the update stage, and a beat that follows one for the same
// wheel takes the freshly written state through a forwarding register, so no
// pattern of wheels slows the stream. Per-wheel valid bits make the state read as
// zero after reset, with no clearing pass. A wheel index at or above WHEELS yields
// a drive of zero and leaves all state untouched.
// Registers (APB, 32-bit data, words at 0x0, 0x4, 0x8): proportional, integral and
// derivative gain, unsigned Q8.8, reset values 4.0, 1.0 and 0.0.
module wheel_speed_pid_antiwindup #(
  parameter int WHEELS = wspa_pkg::WHEELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_wheel_index,
  input  logic signed [wspa_pkg::SPEED_W-1:0] in_measured_speed,
  input  logic signed [wspa_pkg::SPEED_W-1:0] in_target_speed,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [wspa_pkg::SPEED_W-1:0] out_drive_out,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [wspa_pkg::PADDR_W-1:0]        paddr,
  input  logic [wspa_pkg::PDATA_W-1:0]        pwdata,
  output logic [wspa_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready
);
  import wspa_pkg::*;

  localparam int AW = (WHEELS > 1) ? $clog2(WHEELS) : 1;

  gains_t gains;

  logic en1, en2, en3, en4, en5;
  logic v1_r, v2_r, v3_r, v4_r, ov_r;

  logic signed [ERR_W-1:0] err_raw, err_nxt;
  logic                    inc_en_nxt, inrange_nxt, allow;
  logic [AW-1:0]           addr_nxt;

  logic [AW-1:0]           wheel1_r, wheel2_r;
  logic                    inr1_r, inr2_r, inr3_r, inr4_r;
  logic signed [ERR_W-1:0] err1_r, err2_r;
  logic                    inc_en1_r;

  logic signed [INC_W-1:0]  inc_nxt, inc2_r;

  state_t                     st_rd, st_wr;
  logic                       rd_en, wr_en;
  logic signed [ISUM_W-1:0]   isum, isum_clamp;
  logic signed [INTEG_W-1:0]  integ_nxt, integ3_r, integ4_r;
  logic signed [PDIFF_W-1:0]  pdiff_nxt, pdiff3_r;
  logic signed [DDIFF_W-1:0]  ddiff_nxt, ddiff3_r;

  logic signed [PPROD_W-1:0]  p_nxt, p4_r;
  logic signed [DPROD_W-1:0]  d_nxt, d4_r;

  logic signed [SUM_W-1:0]    sum, sum_clamp, sum_shift;
  logic signed [SPEED_W-1:0]  drive_nxt, drive_r;

  wspa_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .gains   (gains)
  );

  wspa_state_mem #(
    .WHEELS (WHEELS)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (wheel1_r),
    .rd_data (st_rd),
    .wr_en   (wr_en),
    .wr_addr (wheel2_r),
    .wr_data (st_wr)
  );

  assign en5      = !ov_r || out_ready;
  assign en4      = !v4_r || en5;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) ov_r <= v4_r;
    end
  end

  always_comb begin
    err_raw = ERR_W'(in_target_speed) - ERR_W'(in_measured_speed);
    if ((err_raw > -ERR_DEADBAND) && (err_raw < ERR_DEADBAND)) begin
      err_nxt = '0;
    end else begin
      err_nxt = err_raw;
    end
    if (in_measured_speed > WINDUP_SPEED) begin
      allow = err_nxt < 0;
    end else if (in_measured_speed < -WINDUP_SPEED) begin
      allow = err_nxt > 0;
    end else begin
      allow = 1'b1;
    end
    inc_en_nxt  = allow && (err_nxt <= ERR_SEP_LIMIT) && (err_nxt >= -ERR_SEP_LIMIT);
    inrange_nxt = {{(IDX_W-2){1'b0}}, in_wheel_index} < IDX_W'(WHEELS);
    addr_nxt    = AW'({{(IDX_W-2){1'b0}}, in_wheel_index});
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      wheel1_r  <= addr_nxt;
      inr1_r    <= inrange_nxt;
      err1_r    <= err_nxt;
      inc_en1_r <= inc_en_nxt;
    end
  end

  assign inc_nxt = inc_en1_r ? ($signed({1'b0, gains.integ}) * err1_r) : INC_W'(0);
  assign rd_en   = en2 && v1_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      wheel2_r <= wheel1_r;
      inr2_r   <= inr1_r;
      err2_r   <= err1_r;
      inc2_r   <= inc_nxt;
    end
  end

  always_comb begin
    isum = ISUM_W'(st_rd.integ) + ISUM_W'(inc2_r);
    if (isum > INTEG_LIM_Q8) begin
      isum_clamp = INTEG_LIM_Q8;
    end else if (isum < -INTEG_LIM_Q8) begin
      isum_clamp = -INTEG_LIM_Q8;
    end else begin
      isum_clamp = isum;
    end
    integ_nxt = INTEG_W'(isum_clamp);
    pdiff_nxt = PDIFF_W'(err2_r) - st_rd.prev_err;
    ddiff_nxt = DDIFF_W'(err2_r) - (DDIFF_W'(st_rd.prev_err) <<< 1)
              + DDIFF_W'(st_rd.prev_prev_err);
    st_wr.prev_err      = PE_W'(err2_r);
    st_wr.prev_prev_err = st_rd.prev_err;
    st_wr.integ         = integ_nxt;
  end

  assign wr_en = v2_r && en3 && inr2_r;

  always_ff @(posedge clk) begin
    if (en3) begin
      inr3_r   <= inr2_r;
      pdiff3_r <= pdiff_nxt;
      ddiff3_r <= ddiff_nxt;
      integ3_r <= integ_nxt;
    end
  end

  assign p_nxt = $signed({1'b0, gains.prop}) * pdiff3_r;
  assign d_nxt = $signed({1'b0, gains.deriv}) * ddiff3_r;

  always_ff @(posedge clk) begin
    if (en4) begin
      inr4_r   <= inr3_r;
      p4_r     <= p_nxt;
      d4_r     <= d_nxt;
      integ4_r <= integ3_r;
    end
  end

  always_comb begin
    sum = SUM_W'(p4_r) + SUM_W'(d4_r) + SUM_W'(integ4_r);
    if (sum > OUT_LIM_Q8) begin
      sum_clamp = OUT_LIM_Q8;
    end else if (sum < -OUT_LIM_Q8) begin
      sum_clamp = -OUT_LIM_Q8;
    end else begin
      sum_clamp = sum;
    end
    if (sum_clamp < 0) begin
      sum_shift = (sum_clamp + $signed(ROUND_NEG)) >>> FRAC_W;
    end else begin
      sum_shift = sum_clamp >>> FRAC_W;
    end
    drive_nxt = inr4_r ? SPEED_W'(sum_shift) : '0;
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      drive_r <= drive_nxt;
    end
  end

  assign out_valid     = ov_r;
  assign out_drive_out = drive_r;

  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (drive_r <= DRIVE_LIM) && (drive_r >= -DRIVE_LIM))
    else $error("drive beyond saturation limit");

  a_integ_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (ISUM_W'(st_wr.integ) <= INTEG_LIM_Q8) &&
              (ISUM_W'(st_wr.integ) >= -INTEG_LIM_Q8))
    else $error("integral written beyond clamp");

  a_forward: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && rd_en && (wheel2_r == wheel1_r)) |=> (st_rd == $past(st_wr)))
    else $error("same-wheel update not forwarded");

  a_deadband: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> (err1_r == 0) || (err1_r >= ERR_DEADBAND) || (err1_r <= -ERR_DEADBAND))
    else $error("error inside deadband not zeroed");

endmodule
